FILE: hdl/plws_pkg.sv
package plws_pkg;

   localparam int RTT_W      = 16;
   localparam int GOOD_W     = 32;
   localparam int SINCE_W    = 32;
   localparam int GRACE_W    = 32;
   localparam int THRESH_W   = 16;
   localparam int REASON_W   = 3;
   localparam int COUNT_W    = 32;
   localparam int MEAN_W     = 24;
   localparam int VAR_W      = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_JOIN_GRACE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOOD_THRESH = 2'd1;

   localparam logic [GRACE_W-1:0]  GRACE_RESET  = 32'd20000;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd3;

   localparam logic [REASON_W-1:0] RSN_NONE       = 3'd0;
   localparam logic [REASON_W-1:0] RSN_BOTH_ZERO  = 3'd1;
   localparam logic [REASON_W-1:0] RSN_PEER_ZERO  = 3'd2;
   localparam logic [REASON_W-1:0] RSN_LOCAL_ZERO = 3'd3;
   localparam logic [REASON_W-1:0] RSN_BACK_UDP   = 3'd4;

   typedef struct packed {
      logic ready;
      logic acc_clear;
      logic rd_issue;
      logic mul_run;
      logic div_start;
      logic div_sel_var;
      logic store_mean;
      logic store_var;
      logic load_out;
   } plws_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_stamp;
      logic last_issue;
      logic pipe_busy;
      logic div_done;
      logic out_free;
   } plws_sts_type;

endpackage

FILE: hdl/plws_if.sv
interface plws_req_if import plws_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RTT_W-1:0]    rtt_ms;
   logic                has_stamp;
   logic [GOOD_W-1:0]   remote_good;
   logic [GOOD_W-1:0]   local_good;
   logic                crypto_ready;
   logic [SINCE_W-1:0]  since_join_ms;

   modport source (output valid, rtt_ms, has_stamp, remote_good, local_good, crypto_ready,
                   since_join_ms, input ready);
   modport sink (input valid, rtt_ms, has_stamp, remote_good, local_good, crypto_ready,
                 since_join_ms, output ready);
endinterface

interface plws_rsp_if import plws_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                datagram_mode;
   logic [REASON_W-1:0] change_reason;
   logic [COUNT_W-1:0]  report_count;
   logic [MEAN_W-1:0]   mean_q8;
   logic [VAR_W-1:0]    variance_q8;

   modport source (output valid, datagram_mode, change_reason, report_count, mean_q8,
                   variance_q8, input ready);
   modport sink (input valid, datagram_mode, change_reason, report_count, mean_q8,
                 variance_q8, output ready);
endinterface

FILE: hdl/plws_divider.sv
module plws_divider import plws_pkg::*; #(
   parameter int DVW = 51,
   parameter int DSW = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic [DVW-1:0] quotient,
   output logic           done
);

   localparam int CW = $clog2(DVW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DVW-1:0] quo_ff, quo_in;
   logic [DSW-1:0] rem_ff, rem_in;
   logic [DSW-1:0] dsr_ff, dsr_in;
   logic [DSW:0]   shifted;
   logic [DSW:0]   diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVW-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVW);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVW-2:0], ge};
         rem_in = ge ? diff[DSW-1:0] : shifted[DSW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: hdl/plws_datapath.sv
module plws_datapath import plws_pkg::*; #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   plws_req_if.sink              req,
   plws_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  plws_cmd_type          cmd,
   output plws_sts_type          sts
);

   localparam int AW  = $clog2(WINDOW);
   localparam int NW  = $clog2(WINDOW + 1);
   localparam int SW  = RTT_W + NW;
   localparam int QW  = 2 * RTT_W + NW;
   localparam int DW  = QW + NW;
   localparam int MW  = SW + 8;
   localparam int VDW = DW + 9;
   localparam int NNW = 2 * NW;

   logic accept;

   logic [GRACE_W-1:0]  grace_ff, grace_in;
   logic [THRESH_W-1:0] thr_ff, thr_in;
   logic                udp_ff, udp_in;
   logic [REASON_W-1:0] reason_ff, reason_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, sq_vld_ff;
   logic [MEAN_W-1:0]   last_mean_ff, last_mean_in;
   logic [VAR_W-1:0]    last_var_ff, last_var_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [RTT_W-1:0]    mem [WINDOW];
   logic [RTT_W-1:0]    rd_data_ff;
   logic [RTT_W-1:0]    x_ff;
   logic [2*RTT_W-1:0]  sq_ff;
   logic [SW-1:0]       s_ff;
   logic [QW-1:0]       q_ff;
   logic [DW-1:0]       nq_ff, ss_ff, d_ff;
   logic [NNW-1:0]      nn_ff;

   logic                rg_zero, lg_zero, fall, rise;
   logic [VDW-1:0]      mean_dvd, var_dvd, dvd, quotient;
   logic [NNW-1:0]      dsr;
   logic                div_done;

   assign req.ready = cmd.ready;
   assign accept    = req.valid & cmd.ready;

   // mode selection
   always_comb begin
      rg_zero   = req.remote_good == '0;
      lg_zero   = req.local_good == '0;
      fall      = req.crypto_ready && udp_ff && (rg_zero || lg_zero)
                  && (req.since_join_ms > grace_ff);
      rise      = req.crypto_ready && !udp_ff
                  && (req.remote_good > GOOD_W'(thr_ff))
                  && (req.local_good > GOOD_W'(thr_ff));
      udp_in    = udp_ff;
      reason_in = reason_ff;
      if (accept) begin
         reason_in = RSN_NONE;
         if (fall) begin
            udp_in = 1'b0;
            if (rg_zero && lg_zero) begin
               reason_in = RSN_BOTH_ZERO;
            end else if (rg_zero) begin
               reason_in = RSN_PEER_ZERO;
            end else begin
               reason_in = RSN_LOCAL_ZERO;
            end
         end else if (rise) begin
            udp_in    = 1'b1;
            reason_in = RSN_BACK_UDP;
         end
      end
   end

   always_comb begin
      grace_in = grace_ff;
      thr_in   = thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_JOIN_GRACE:  grace_in = csr_wdata[GRACE_W-1:0];
            CSR_GOOD_THRESH: thr_in   = csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      n_in      = n_ff;
      wr_ptr_in = wr_ptr_ff;
      if (accept) begin
         if (count_ff != '1) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (req.has_stamp) begin
            if (n_ff != NW'(WINDOW)) begin
               n_in = n_ff + NW'(1);
            end
            wr_ptr_in = (wr_ptr_ff == AW'(WINDOW - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
      end
      rd_idx_in = rd_idx_ff;
      if (cmd.acc_clear) begin
         rd_idx_in = '0;
      end else if (cmd.rd_issue) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
      last_mean_in = cmd.store_mean ? quotient[MEAN_W-1:0] : last_mean_ff;
      last_var_in  = cmd.store_var ? quotient[VAR_W-1:0] : last_var_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff     <= GRACE_RESET;
         thr_ff       <= THRESH_RESET;
         udp_ff       <= 1'b0;
         reason_ff    <= RSN_NONE;
         count_ff     <= '0;
         n_ff         <= '0;
         wr_ptr_ff    <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         last_mean_ff <= '0;
         last_var_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grace_ff     <= grace_in;
         thr_ff       <= thr_in;
         udp_ff       <= udp_in;
         reason_ff    <= reason_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= cmd.rd_issue;
         sq_vld_ff    <= rd_vld_ff;
         last_mean_ff <= last_mean_in;
         last_var_ff  <= last_var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample window
   always_ff @(posedge clock) begin
      if (accept && req.has_stamp) begin
         mem[wr_ptr_ff] <= req.rtt_ms;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // sums, products, differences
   always_ff @(posedge clock) begin
      x_ff  <= rd_data_ff;
      sq_ff <= rd_data_ff * rd_data_ff;
      if (cmd.acc_clear) begin
         s_ff <= '0;
         q_ff <= '0;
      end else if (sq_vld_ff) begin
         s_ff <= s_ff + SW'(x_ff);
         q_ff <= q_ff + QW'(sq_ff);
      end
      if (cmd.mul_run) begin
         nq_ff <= DW'(n_ff) * DW'(q_ff);
         ss_ff <= DW'(s_ff) * DW'(s_ff);
         nn_ff <= NNW'(n_ff) * NNW'(n_ff);
      end
      d_ff <= nq_ff - ss_ff;
   end

   assign mean_dvd = VDW'({s_ff, 8'h00} + MW'(n_ff >> 1));
   assign var_dvd  = {1'b0, d_ff, 8'h00} + VDW'(nn_ff >> 1);
   assign dvd      = cmd.div_sel_var ? var_dvd : mean_dvd;
   assign dsr      = cmd.div_sel_var ? nn_ff : NNW'(n_ff);

   plws_divider #(
      .DVW (VDW),
      .DSW (NNW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp.datagram_mode <= udp_ff;
         rsp.change_reason <= reason_ff;
         rsp.report_count  <= count_ff;
         rsp.mean_q8       <= last_mean_ff;
         rsp.variance_q8   <= last_var_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   always_comb begin
      sts.req_valid  = req.valid;
      sts.req_stamp  = req.has_stamp;
      sts.last_issue = NW'(rd_idx_ff) == (n_ff - NW'(1));
      sts.pipe_busy  = rd_vld_ff | sq_vld_ff;
      sts.div_done   = div_done;
      sts.out_free   = !rsp_valid_ff | rsp.ready;
   end

   a_store_on_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_mean || cmd.store_var) |-> div_done)
      else $error("statistic stored without divider completion");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(WINDOW))
      else $error("window fill count above depth");

   a_read_in_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (NW'(rd_idx_ff) < n_ff))
      else $error("window read beyond stored samples");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp.ready))
      else $error("output word overwritten before taken");

endmodule

FILE: hdl/plws_ctrl.sv
module plws_ctrl import plws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  plws_sts_type sts,
   output plws_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIVM  = 3'd4;
   localparam logic [2:0] ST_DIVV  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (sts.req_valid) begin
               if (sts.req_stamp) begin
                  cmd.acc_clear = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_run   = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_DIVM;
         end
         ST_DIVM: begin
            if (sts.div_done) begin
               cmd.store_mean  = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_sel_var = 1'b1;
               state_in        = ST_DIVV;
            end
         end
         ST_DIVV: begin
            cmd.div_sel_var = 1'b1;
            if (sts.div_done) begin
               cmd.store_var = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/ping_latency_window_stats_unit.sv
// a report without timestamp goes from accept through the done state to the rsp register;
// with timestamp the work is one window read per cycle over the n stored samples, then
// two passes (mean, then variance) of a one-bit-per-cycle divider; one report in work
// at a time, the next is taken while the previous rsp word waits
// reset: synchronous, clears window fill, counters, mode and config to defaults
module ping_latency_window_stats_unit import plws_pkg::*; #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   plws_req_if.sink              req_chan,
   plws_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   plws_cmd_type cmd;
   plws_sts_type sts;

   plws_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   plws_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: test/tb_ping_latency_window_stats_unit.sv
`timescale 1ns / 100ps

module tb_ping_latency_window_stats_unit;
   import plws_pkg::*;

   localparam int WINDOW = 16;
   localparam int TAIL_CYCLES = 160;
   localparam int PHASE_ITEMS = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [RTT_W-1:0]   rtt_ms;
      logic               has_stamp;
      logic [GOOD_W-1:0]  remote_good;
      logic [GOOD_W-1:0]  local_good;
      logic               crypto_ready;
      logic [SINCE_W-1:0] since_join_ms;
   } ping_word_type;

   typedef struct {
      logic                datagram_mode;
      logic [REASON_W-1:0] change_reason;
      logic [COUNT_W-1:0]  report_count;
      logic [MEAN_W-1:0]   mean_q8;
      logic [VAR_W-1:0]    variance_q8;
   } stats_word_type;

   class stats_board_type;
      logic [GRACE_W-1:0]  grace;
      logic [THRESH_W-1:0] thresh;
      logic [RTT_W-1:0]    rtt_hist[WINDOW];
      logic [COUNT_W-1:0]  reports;
      int unsigned         filled;
      logic                udp_mode;
      logic [MEAN_W-1:0]   mean;
      logic [VAR_W-1:0]    variance;
      stats_word_type      expected_stats[$];
      int unsigned         errors;

      function new();
         grace = GRACE_RESET;
         thresh = THRESH_RESET;
         foreach (rtt_hist[k]) rtt_hist[k] = '0;
         reports = '0;
         filled = 0;
         udp_mode = 1'b0;
         mean = '0;
         variance = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_JOIN_GRACE: grace = data[GRACE_W-1:0];
            CSR_GOOD_THRESH: thresh = data[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      function void note_report(ping_word_type r);
         stats_word_type e;
         logic [REASON_W-1:0] reason;
         logic [63:0] s, q, n, d, nn;
         reason = RSN_NONE;
         if (r.crypto_ready) begin
            if (udp_mode && (r.remote_good == 0 || r.local_good == 0) &&
                r.since_join_ms > grace) begin
               udp_mode = 1'b0;
               if (r.remote_good == 0 && r.local_good == 0) reason = RSN_BOTH_ZERO;
               else if (r.remote_good == 0) reason = RSN_PEER_ZERO;
               else reason = RSN_LOCAL_ZERO;
            end else if (!udp_mode && r.remote_good > GOOD_W'(thresh) &&
                         r.local_good > GOOD_W'(thresh)) begin
               udp_mode = 1'b1;
               reason = RSN_BACK_UDP;
            end
         end
         if (reports != '1) reports++;
         if (r.has_stamp) begin
            if (filled < WINDOW) begin
               rtt_hist[filled] = r.rtt_ms;
               filled++;
            end else begin
               for (int k = 1; k < WINDOW; k++) rtt_hist[k-1] = rtt_hist[k];
               rtt_hist[WINDOW-1] = r.rtt_ms;
            end
            s = 0;
            q = 0;
            for (int k = 0; k < filled; k++) begin
               s += 64'(rtt_hist[k]);
               q += 64'(rtt_hist[k]) * 64'(rtt_hist[k]);
            end
            n = 64'(filled);
            d = n * q - s * s;
            nn = n * n;
            mean = MEAN_W'(((s << 8) + n / 2) / n);
            variance = VAR_W'(((d << 8) + nn / 2) / nn);
         end
         e.datagram_mode = udp_mode;
         e.change_reason = reason;
         e.report_count = reports;
         e.mean_q8 = mean;
         e.variance_q8 = variance;
         expected_stats.insert(expected_stats.size(), e);
      endfunction

      task check_stats(stats_word_type got);
         stats_word_type e;
         if (expected_stats.size() == 0) begin
            report("result word with nothing expected");
         end else begin
            e = expected_stats.pop_front();
            if (got.datagram_mode !== e.datagram_mode)
               report($sformatf("report %0d datagram_mode %0b, want %0b",
                                e.report_count, got.datagram_mode, e.datagram_mode));
            if (got.change_reason !== e.change_reason)
               report($sformatf("report %0d change_reason %0d, want %0d",
                                e.report_count, got.change_reason, e.change_reason));
            if (got.report_count !== e.report_count)
               report($sformatf("report_count %0d, want %0d",
                                got.report_count, e.report_count));
            if (got.mean_q8 !== e.mean_q8)
               report($sformatf("report %0d mean_q8 %0d, want %0d",
                                e.report_count, got.mean_q8, e.mean_q8));
            if (got.variance_q8 !== e.variance_q8)
               report($sformatf("report %0d variance_q8 %0d, want %0d",
                                e.report_count, got.variance_q8, e.variance_q8));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit quiet_run = 1'b0;
   stats_board_type board = new();

   plws_req_if req_if();
   plws_rsp_if rsp_if();

   ping_latency_window_stats_unit #(.WINDOW(WINDOW)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic ping_word_type make_report(logic [RTT_W-1:0] rtt, logic stamp,
                                                 logic [GOOD_W-1:0] rg, logic [GOOD_W-1:0] lg,
                                                 logic crypto, logic [SINCE_W-1:0] since);
      ping_word_type r;
      r.rtt_ms = rtt;
      r.has_stamp = stamp;
      r.remote_good = rg;
      r.local_good = lg;
      r.crypto_ready = crypto;
      r.since_join_ms = since;
      return r;
   endfunction

   function automatic logic [GOOD_W-1:0] pick_good();
      case ($urandom_range(5))
         0: return '0;
         1: return GOOD_W'(board.thresh);
         2: return GOOD_W'(board.thresh) + 1;
         3: return $urandom;
         4: return '1;
         default: return $urandom_range(0, 10);
      endcase
   endfunction

   function automatic logic [SINCE_W-1:0] pick_since();
      case ($urandom_range(4))
         0: return board.grace;
         1: return board.grace + 1;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic ping_word_type rand_report();
      ping_word_type r;
      if ($urandom_range(99) < 15) begin
         r = make_report(RTT_W'($urandom), 1'($urandom), $urandom, $urandom,
                         1'($urandom), $urandom);
      end else begin
         case ($urandom_range(3))
            0: r.rtt_ms = RTT_W'($urandom);
            3: r.rtt_ms = $urandom_range(1) ? '1 : '0;
            default: r.rtt_ms = RTT_W'($urandom_range(10, 400));
         endcase
         r.has_stamp = $urandom_range(99) < 75;
         r.remote_good = pick_good();
         r.local_good = pick_good();
         r.crypto_ready = $urandom_range(99) < 85;
         r.since_join_ms = pick_since();
      end
      return r;
   endfunction

   task automatic send_report(ping_word_type r);
      if (!quiet_run && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rtt_ms <= r.rtt_ms;
      req_if.has_stamp <= r.has_stamp;
      req_if.remote_good <= r.remote_good;
      req_if.local_good <= r.local_good;
      req_if.crypto_ready <= r.crypto_ready;
      req_if.since_join_ms <= r.since_join_ms;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_report(r);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_stats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic configure(logic [GRACE_W-1:0] grace, logic [THRESH_W-1:0] thresh);
      csr_put(CSR_JOIN_GRACE, grace);
      csr_put(CSR_GOOD_THRESH, {16'($urandom), thresh});
      csr_put(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int burst_from, int burst_to);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         quiet_run = (k >= burst_from && k < burst_to);
         send_report(rand_report());
      end
      quiet_run = 1'b0;
   endtask

   // result side: check at the edge, then pick ready for the next cycle
   initial begin
      stats_word_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.datagram_mode = rsp_if.datagram_mode;
            got.change_reason = rsp_if.change_reason;
            got.report_count = rsp_if.report_count;
            got.mean_q8 = rsp_if.mean_q8;
            got.variance_q8 = rsp_if.variance_q8;
            board.check_stats(got);
         end
         rsp_if.ready <= quiet_run || ($urandom_range(99) >= 28);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_ping_latency_window_stats_unit NOT OK");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.rtt_ms <= '0;
      req_if.has_stamp <= 1'b0;
      req_if.remote_good <= '0;
      req_if.local_good <= '0;
      req_if.crypto_ready <= 1'b0;
      req_if.since_join_ms <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset defaults
      send_report(make_report(16'd100, 1'b0, '0, '0, 1'b0, '0));
      send_report(make_report('0, 1'b1, '0, '0, 1'b1, '0));
      send_report(make_report('1, 1'b1, 32'd4, 32'd4, 1'b0, '1));
      send_report(make_report(16'd50, 1'b1, 32'd4, 32'd4, 1'b1, '0));
      send_report(make_report(16'd60, 1'b1, '0, '0, 1'b1, 32'd20000));
      send_report(make_report(16'd70, 1'b1, '0, '0, 1'b1, 32'd20001));
      send_report(make_report(16'd80, 1'b1, '1, '1, 1'b1, '0));
      send_report(make_report('1, 1'b1, '0, 32'd5, 1'b1, '1));
      send_report(make_report('0, 1'b1, 32'd3, 32'd100, 1'b1, '1));
      send_report(make_report(16'd1, 1'b1, 32'd100, 32'd100, 1'b1, '1));
      send_report(make_report(16'd2, 1'b1, 32'd7, '0, 1'b1, '1));
      // fill the window past its depth with extreme samples
      for (int k = 0; k < 14; k++)
         send_report(make_report((k % 2) ? '1 : '0, 1'b1, $urandom, $urandom, 1'b0, $urandom));
      drain();

      configure('0, '0);
      random_phase(PHASE_ITEMS, PHASE_ITEMS);
      drain();

      configure('1, '1);
      random_phase(PHASE_ITEMS, PHASE_ITEMS);
      drain();

      configure($urandom_range(0, 100000), THRESH_W'($urandom_range(0, 20)));
      random_phase(20, 80);
      drain();

      configure(GRACE_RESET, THRESH_RESET);
      random_phase(PHASE_ITEMS, PHASE_ITEMS);
      drain();

      if (board.errors == 0) begin
         $display("tb_ping_latency_window_stats_unit OK");
      end else begin
         $display("tb_ping_latency_window_stats_unit NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/plws_pkg.sv
hdl/plws_if.sv
hdl/plws_divider.sv
hdl/plws_datapath.sv
hdl/plws_ctrl.sv
hdl/ping_latency_window_stats_unit.sv
test/tb_ping_latency_window_stats_unit.sv
